// ===== src/life_rule_row_stream_defines.svh =====
// Assertion macros for the RTL of the Life row stream.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef LIFE_RULE_ROW_STREAM_DEFINES_SVH
`define LIFE_RULE_ROW_STREAM_DEFINES_SVH

`ifndef SYNTHESIS

`define LRS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define LRS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define LRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define LRS_ASSERT_ALWAYS(lbl, cond, msg)

`define LRS_ASSERT_IMPL(lbl, ante, cons, msg)

`define LRS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== src/lrs_pkg.sv =====
`default_nettype none

package lrs_pkg;

  localparam int WORD_CELLS    = 32;
  localparam int MAX_ROW_WORDS = 64;
  localparam int ROW_CELLS_W   = 12;
  localparam int COL_W         = 6;
  localparam int POS_W         = 5;
  localparam int NCELL_W       = 6;

  localparam logic [ROW_CELLS_W-1:0] MAX_ROW_CELLS =
    ROW_CELLS_W'(MAX_ROW_WORDS * WORD_CELLS);

  typedef logic [WORD_CELLS-1:0] word_t;
  typedef word_t [2:0]           triple_t;
  typedef logic [COL_W-1:0]      col_t;
  typedef logic [NCELL_W-1:0]    ncell_t;

  // One bit of each of the three rows at the given cell position.
  function automatic logic [2:0] pick_bits(input triple_t w, input logic [POS_W-1:0] pos);
    return {w[2][pos], w[1][pos], w[0][pos]};
  endfunction

  // Next generation of the first n cells of a word (n is 1 to 32). The left and right
  // arguments hold the outer neighbor cell of each of the three rows.
  function automatic word_t gen_word(input triple_t w, input logic [2:0] left,
                                     input logic [2:0] right, input ncell_t n);
    logic [WORD_CELLS+1:0] ext [3];
    word_t                 mask;
    word_t                 res;
    ncell_t                np1;
    logic [3:0]            cnt;
    mask = (n >= NCELL_W'(WORD_CELLS)) ? '1 : ((WORD_CELLS'(1) << n) - WORD_CELLS'(1));
    np1  = n + NCELL_W'(1);
    for (int r = 0; r < 3; r++) begin
      ext[r] = (WORD_CELLS+2)'(left[r])
             | ((WORD_CELLS+2)'(w[r] & mask) << 1)
             | ((WORD_CELLS+2)'(right[r]) << np1);
    end
    res = '0;
    for (int i = 0; i < WORD_CELLS; i++) begin
      cnt = 4'(ext[0][i]) + 4'(ext[0][i+1]) + 4'(ext[0][i+2])
          + 4'(ext[1][i]) + 4'(ext[1][i+2])
          + 4'(ext[2][i]) + 4'(ext[2][i+1]) + 4'(ext[2][i+2]);
      res[i] = (cnt == 4'd3) || (ext[1][i+1] && (cnt == 4'd2));
    end
    return res & mask;
  endfunction

endpackage

`default_nettype wire

// ===== src/lrs_in_if.sv =====
`default_nettype none

interface lrs_in_if;
  import lrs_pkg::*;

  logic  valid;
  logic  ready;
  word_t above_word;
  word_t centre_word;
  word_t below_word;

  modport source (output valid, output above_word, output centre_word, output below_word,
                  input ready);
  modport sink (input valid, input above_word, input centre_word, input below_word,
                output ready);
endinterface

`default_nettype wire

// ===== src/lrs_out_if.sv =====
`default_nettype none

interface lrs_out_if;
  import lrs_pkg::*;

  logic  valid;
  logic  ready;
  col_t  word_column;
  word_t next_word;
  logic  run_last;

  modport source (output valid, output word_column, output next_word, output run_last,
                  input ready);
  modport sink (input valid, input word_column, input next_word, input run_last,
                output ready);
endinterface

`default_nettype wire

// ===== src/life_rule_row_stream.sv =====
// Life row stream: next generation (birth on 3, survival on 2 or 3) of one grid row,
// 32 packed cells per word, with horizontal wrap over row_cells cells.
// in_chan: one transaction per word column, in column order, carrying the above, centre
//   and below row words. The host supplies the vertical wrap rows itself.
// out_chan: next-generation words with their word column. Word 0 is held back until the
//   row ends; column k delivers word k-1, and the last column of the row delivers up to
//   three words (k-1, k, then 0). run_last marks the last word of one input transaction.
// cfg_wr_en/cfg_wr_data: row width in cells; write it only while the block is idle.
// Each result passes through the input register and then the result buffer.
// Throughput: one input transaction per cycle while each yields at most one word and the
//   receiver is ready; a row-end transaction's words leave one at a time by the single output port.
// A stalled receiver fills the result buffer, then the input register, then drops
//   in_chan.ready; nothing is lost.
// Reset (rst_n low at a clock edge) empties both stages, returns to word column 0 and
// sets the row width to 2048 cells.
`default_nettype none

module life_rule_row_stream (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [lrs_pkg::ROW_CELLS_W-1:0] cfg_wr_data,
  lrs_in_if.sink                          in_chan,
  lrs_out_if.source                       out_chan
);
  import lrs_pkg::*;

  `include "life_rule_row_stream_defines.svh"

  // Row geometry, kept in derived form.
  col_t                   last_col_r;
  ncell_t                 nlast_r;
  logic [ROW_CELLS_W-1:0] cfg_rc;
  logic [ROW_CELLS_W-1:0] cfg_rc_m1;
  col_t                   cfg_last_col;
  ncell_t                 cfg_nlast;

  // Input register.
  logic    stg_vld_r;
  triple_t stg_r;

  // Row state.
  col_t       col_cnt_r;
  triple_t    prev_r;
  triple_t    first_r;
  logic [2:0] ppr_r;
  logic [2:0] slb_r;

  // Result buffer: up to three words per input transaction.
  logic [2:0] slot_vld_r;
  col_t       slot_col_r [3];
  word_t      slot_word_r [3];

  col_t       k;
  logic       is_last;
  logic       one_word;
  logic [2:0] cur_left;
  logic [2:0] cur_end;
  logic [2:0] slb_eff;
  word_t      word_a;
  word_t      word_b;
  word_t      word_c;
  logic [2:0] new_vld;
  logic [1:0] sel_idx;
  logic [2:0] sel_oh;
  logic [2:0] remain;
  logic       take;
  logic       buf_free;
  logic       adv;
  logic       in_acc;

  always_comb begin
    if (cfg_wr_data == '0) begin
      cfg_rc = ROW_CELLS_W'(1);
    end else if (cfg_wr_data > MAX_ROW_CELLS) begin
      cfg_rc = MAX_ROW_CELLS;
    end else begin
      cfg_rc = cfg_wr_data;
    end
    cfg_rc_m1    = cfg_rc - ROW_CELLS_W'(1);
    cfg_last_col = COL_W'(cfg_rc_m1 >> POS_W);
    cfg_nlast    = NCELL_W'(cfg_rc - {cfg_last_col, {POS_W{1'b0}}});
  end

  always_comb begin
    k        = (col_cnt_r > last_col_r) ? last_col_r : col_cnt_r;
    is_last  = (k == last_col_r);
    one_word = (last_col_r == '0);
    cur_left = pick_bits(stg_r, POS_W'(0));
    cur_end  = pick_bits(stg_r, POS_W'(nlast_r - NCELL_W'(1)));
    // Column 1 records its left bits in the same step that may close a two-word row.
    slb_eff  = (k == COL_W'(1)) ? cur_left : slb_r;
    word_a   = gen_word(prev_r, ppr_r, cur_left, NCELL_W'(WORD_CELLS));
    word_b   = gen_word(stg_r,
                        one_word ? cur_end : pick_bits(prev_r, POS_W'(WORD_CELLS - 1)),
                        one_word ? cur_left : pick_bits(first_r, POS_W'(0)),
                        nlast_r);
    word_c   = gen_word(first_r, cur_end, slb_eff, NCELL_W'(WORD_CELLS));
    new_vld  = {is_last && !one_word, is_last, k >= COL_W'(2)};
  end

  always_comb begin
    priority if (slot_vld_r[0]) begin
      sel_idx = 2'd0;
    end else if (slot_vld_r[1]) begin
      sel_idx = 2'd1;
    end else begin
      sel_idx = 2'd2;
    end
    sel_oh   = slot_vld_r & (~slot_vld_r + 3'd1);
    remain   = slot_vld_r & ~sel_oh;
    take     = out_chan.valid && out_chan.ready;
    buf_free = (slot_vld_r == '0) || (take && (remain == '0));
    adv      = stg_vld_r && buf_free;
    in_acc   = in_chan.valid && in_chan.ready;
  end

  assign in_chan.ready        = !stg_vld_r || adv;
  assign out_chan.valid       = |slot_vld_r;
  assign out_chan.word_column = slot_col_r[sel_idx];
  assign out_chan.next_word   = slot_word_r[sel_idx];
  assign out_chan.run_last    = (remain == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_col_r <= COL_W'(MAX_ROW_WORDS - 1);
      nlast_r    <= NCELL_W'(WORD_CELLS);
      stg_vld_r  <= 1'b0;
      col_cnt_r  <= '0;
      ppr_r      <= '0;
      slb_r      <= '0;
      slot_vld_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        last_col_r <= cfg_last_col;
        nlast_r    <= cfg_nlast;
      end
      if (in_acc) begin
        stg_vld_r <= 1'b1;
      end else if (adv) begin
        stg_vld_r <= 1'b0;
      end
      if (adv) begin
        col_cnt_r  <= is_last ? '0 : k + COL_W'(1);
        ppr_r      <= pick_bits(prev_r, POS_W'(WORD_CELLS - 1));
        if (k == COL_W'(1)) begin
          slb_r <= cur_left;
        end
        slot_vld_r <= new_vld;
      end else if (take) begin
        slot_vld_r <= remain;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      stg_r <= {in_chan.below_word, in_chan.centre_word, in_chan.above_word};
    end
    if (adv) begin
      prev_r <= stg_r;
      if (k == '0) begin
        first_r <= stg_r;
      end
      slot_col_r[0]  <= k - COL_W'(1);
      slot_word_r[0] <= word_a;
      slot_col_r[1]  <= k;
      slot_word_r[1] <= word_b;
      slot_col_r[2]  <= '0;
      slot_word_r[2] <= word_c;
    end
  end

  `LRS_ASSERT_ALWAYS(a_slot_order, !(slot_vld_r[2] && slot_vld_r[0]) || slot_vld_r[1], "slot gap")
  `LRS_ASSERT_NEXT(a_row_wrap, adv && is_last, col_cnt_r == '0, "no wrap at row end")
  `LRS_ASSERT_NEXT(a_more_words, take && !out_chan.run_last, out_chan.valid, "words lost")
  `LRS_ASSERT_NEXT(a_stage_hold, stg_vld_r && !adv, stg_vld_r && $stable(stg_r), "stage changed")

endmodule

`default_nettype wire
